// ===== rtl/core/dict_enc_pkg.sv =====
// Package for the dictionary encoder: transaction payload types, cell chain types
// and status codes. It has no dependencies and is compiled first.
`default_nettype none

package dict_enc_pkg;

    localparam int VALUE_W = 64;
    localparam int CODE_W  = 8;
    localparam int COUNT_W = 9;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_ADDED    = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd256;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      new_block;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entries_used;
    } out_item_t;

    // Search token that moves one cell per cycle down the chain.
    typedef struct packed {
        logic              active;
        logic              found;
        logic [CODE_W-1:0] idx;
    } token_t;

    // Query that the controller holds and broadcasts to every cell.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] used;
        logic               add_ok;
    } query_t;

endpackage

`default_nettype wire

// ===== rtl/core/dict_enc_cell.sv =====
// One dictionary cell: holds a single 64-bit entry, compares it with the query
// when the search token passes and writes itself on an append. Uses dict_enc_pkg.
`default_nettype none

module dict_enc_cell
    import dict_enc_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire query_t query,
    input  wire token_t tok_in,
    output token_t      tok_out
);

    localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(CELL_IDX);

    logic [VALUE_W-1:0] entry_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               hit;
    logic               write_en;

    // Only entries below the fill count are valid, and those are always written.
    assign hit      = tok_in.active && !tok_in.found && (MY_IDX < query.used)
                      && (entry_reg == query.value);
    // By the time the token reaches the first free cell, every valid entry has been seen.
    assign write_en = tok_in.active && !tok_in.found && (MY_IDX == query.used)
                      && query.add_ok;

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = MY_IDX[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entry_reg <= query.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dictionary_encoder_top.sv =====
// Top level of the dictionary encoder: controller, configuration register and
// the row of dict_enc_cell instances. Uses dict_enc_pkg.
//
//   channel   direction  handshake                payload
//   in        input      in_valid / in_stall      in_item_t  (value, new_block)
//   out       output     out_valid / out_stall    out_item_t (code, status, entries_used)
//   cfg       input      cfg_wr_en                cfg_wr_data (dict_limit)
//
// One transaction is in flight at a time: a new one is not accepted until the current
// one is through. The search token walks the cell row one cell per cycle, and its
// result passes through the result register into the output register, at which
// point the next transaction can be accepted. A finished result waits in the
// output register while the next transaction is accepted; if that result is still
// waiting when the next one finishes, the input stays stalled until it leaves.
// Reset clears the fill count and all control state and sets the limit to 256;
// the dictionary entries themselves are not cleared.
`default_nettype none

module dictionary_encoder_top
    import dict_enc_pkg::*;
#(
    parameter int DICT_SIZE = 256
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data
);

    localparam logic [COUNT_W-1:0] DICT_MAX = COUNT_W'(DICT_SIZE);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] fill_count_reg, fill_count_next;
    query_t             query_reg, query_next;
    logic               launch_reg, launch_next;
    out_item_t          res_reg, res_next;
    out_item_t          out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               out_free;
    logic [COUNT_W-1:0] eff_limit;
    logic [COUNT_W-1:0] used_start;
    token_t             tok [DICT_SIZE+1];
    token_t             tail;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // A limit of zero behaves as one, and anything above the dictionary size saturates.
    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = COUNT_W'(1);
        else if (limit_reg > DICT_MAX)
            eff_limit = DICT_MAX;
        else
            eff_limit = limit_reg;
    end

    assign used_start = in_data.new_block ? '0 : fill_count_reg;

    assign tok[0] = '{active: launch_reg, found: 1'b0, idx: '0};
    assign tail   = tok[DICT_SIZE];

    for (genvar g = 0; g < DICT_SIZE; g++)
    begin : g_cell
        dict_enc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .query   (query_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        query_next      = query_reg;
        launch_next     = 1'b0;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    query_next.value  = in_data.value;
                    query_next.used   = used_start;
                    query_next.add_ok = (used_start < eff_limit);
                    launch_next       = 1'b1;
                    state_next        = S_RUN;
                end
            end
            S_RUN:
            begin
                if (tail.active)
                begin
                    if (tail.found)
                    begin
                        res_next.code         = tail.idx;
                        res_next.status       = ST_FOUND;
                        res_next.entries_used = query_reg.used;
                    end
                    else if (query_reg.add_ok)
                    begin
                        res_next.code         = query_reg.used[CODE_W-1:0];
                        res_next.status       = ST_ADDED;
                        res_next.entries_used = query_reg.used + COUNT_W'(1);
                    end
                    else
                    begin
                        // Rejection never follows new_block, so the count is unchanged.
                        res_next.code         = '0;
                        res_next.status       = ST_REJECTED;
                        res_next.entries_used = query_reg.used;
                    end
                    fill_count_next = res_next.entries_used;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            limit_reg      <= LIMIT_RESET;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            launch_reg     <= launch_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg    <= query_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The search token may only leave the row while a transaction is running.
    a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == S_RUN))
        else $error("search token left the cell row outside a running transaction");

    // Only one token is ever launched per accepted transaction.
    a_launch_once: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |=> !launch_reg)
        else $error("search token launched on consecutive cycles");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= DICT_MAX)
        else $error("fill count exceeds dictionary size");

    // An added entry always leaves at least one entry in use, and found needs one too.
    a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status == ST_ADDED
                           || out_data_reg.status == ST_FOUND))
        |-> (out_data_reg.entries_used != '0))
        else $error("found or added result reports an empty dictionary");

endmodule

`default_nettype wire

// ===== dv/dict_enc_checker.sv =====
// Checker for the dictionary encoder: watches both channels and the limit register,
// predicts each result from its own copy of the dictionary and compares in order.
// Depends on dict_enc_pkg only.
`timescale 1ns / 100ps

module dict_enc_checker
    import dict_enc_pkg::*;
#(
    parameter int DICT_SIZE = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_item_t          out_data,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    output int                 errors,
    output int                 outstanding
);

    logic [VALUE_W-1:0] dict_mem [DICT_SIZE];
    logic [COUNT_W-1:0] fill_cnt;
    logic [COUNT_W-1:0] limit_reg;
    out_item_t          encodings_due [$];
    int                 fail_cnt = 0;

    // Looks the value up in the current block and updates the dictionary copy.
    function automatic out_item_t encode_lookup(input in_item_t item);
        out_item_t res;
        int        used;
        int        lim;
        bit        hit;
        res  = '0;
        hit  = 1'b0;
        used = item.new_block ? 0 : int'(fill_cnt);
        if (used > DICT_SIZE)
            used = DICT_SIZE;
        lim = int'(limit_reg);
        if (lim < 1)
            lim = 1;
        if (lim > DICT_SIZE)
            lim = DICT_SIZE;
        for (int i = 0; i < used; i++)
        begin
            if (!hit && dict_mem[i] == item.value)
            begin
                hit              = 1'b1;
                res.code         = CODE_W'(i);
                res.status       = ST_FOUND;
                res.entries_used = COUNT_W'(used);
            end
        end
        if (hit)
            fill_cnt = COUNT_W'(used);
        else if (used >= lim)
        begin
            // A full dictionary leaves everything as it was.
            res.code         = '0;
            res.status       = ST_REJECTED;
            res.entries_used = fill_cnt;
        end
        else
        begin
            dict_mem[used]   = item.value;
            fill_cnt         = COUNT_W'(used + 1);
            res.code         = CODE_W'(used);
            res.status       = ST_ADDED;
            res.entries_used = fill_cnt;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fill_cnt  = '0;
            limit_reg = LIMIT_RESET;
            encodings_due.delete();
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
            if (in_valid && !in_stall)
                encodings_due.push_back(encode_lookup(in_data));
            if (out_valid && !out_stall)
            begin
                if (encodings_due.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected result code %0d status %0d used %0d",
                                 $time, out_data.code, out_data.status,
                                 out_data.entries_used);
                end
                else
                begin
                    want = encodings_due.pop_front();
                    if (out_data.code !== want.code || out_data.status !== want.status ||
                        out_data.entries_used !== want.entries_used)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"%0t: mismatch expected code %0d status %0d used %0d,",
                                      " got code %0d status %0d used %0d"},
                                     $time, want.code, want.status, want.entries_used,
                                     out_data.code, out_data.status, out_data.entries_used);
                    end
                end
            end
        end
        outstanding <= encodings_due.size();
        errors      <= fail_cnt;
    end

endmodule

// ===== dv/tb.sv =====
// Top of the dictionary encoder testbench: clock, reset, stimulus, limit writes
// and the verdict. Uses dict_enc_pkg, dictionary_encoder_top and dict_enc_checker.
`timescale 1ns / 100ps

module tb;
    import dict_enc_pkg::*;

    localparam int DICT_SIZE      = 256;
    localparam int HOLD_CYCLES    = 900;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    int                 errors;
    int                 outstanding;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;

    dictionary_encoder_top #(.DICT_SIZE(DICT_SIZE)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    dict_enc_checker #(.DICT_SIZE(DICT_SIZE)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Column values: full 64-bit, sign-extended from 8 or 32 bits, or small values below 16.
    function automatic logic [VALUE_W-1:0] column_value();
        logic [31:0] lo;
        lo = $urandom;
        case ($urandom_range(3))
            0:       return {$urandom, lo};
            1:       return {{56{lo[7]}}, lo[7:0]};
            2:       return {{32{lo[31]}}, lo};
            default: return VALUE_W'($urandom_range(15));
        endcase
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v, input bit nb);
        in_item_t item;
        item.value     = v;
        item.new_block = nb;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drains the block, then writes the limit while nothing is in flight.
    task automatic set_limit(input logic [COUNT_W-1:0] lim);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Values drawn mostly from a small pool so that hits, adds and rejects mix.
    task automatic run_mix(input int n, input int pool_n, input int nb_pct);
        logic [VALUE_W-1:0] pool [32];
        for (int i = 0; i < pool_n; i++)
            pool[i] = column_value();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 85)
                send_value(pool[$urandom_range(pool_n - 1)], $urandom_range(99) < nb_pct);
            else
                send_value(column_value(), $urandom_range(99) < nb_pct);
        end
    endtask

    // One block past a full dictionary, then a few values that are already in it.
    task automatic run_fill();
        logic [VALUE_W-1:0] seen [DICT_SIZE + 3];
        for (int i = 0; i < DICT_SIZE + 3; i++)
        begin
            seen[i] = {$urandom, $urandom};
            send_value(seen[i], i == 0);
        end
        for (int i = 0; i < 3; i++)
            send_value(seen[$urandom_range(DICT_SIZE - 1)], 1'b0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Limit from reset: extremes of the value range.
        send_value('0, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value('1, 1'b0);
        send_value(VAL_MIN, 1'b0);

        // Zero acts as one; the limit is now below the fill count.
        set_limit('0);
        send_value(64'd5, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value(64'd5, 1'b1);
        send_value(64'd5, 1'b0);
        send_value(64'd6, 1'b0);

        // Patterns that differ only in the sign bit are distinct entries.
        set_limit(9'd3);
        send_value(64'd1, 1'b0);
        send_value(64'h8000_0000_0000_0001, 1'b0);
        send_value(64'd7, 1'b0);
        send_value(64'd1, 1'b0);

        set_limit(9'd511);
        send_value(64'd7, 1'b0);
        set_limit(9'd300);
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_value(64'h5555_5555_5555_5555, 1'b0);

        send_idle_pct = 19;
        recv_idle_pct = 59;
        set_limit(9'd5);
        run_mix(60, 7, 8);
        set_limit(9'd1);
        run_mix(40, 3, 10);

        send_idle_pct = 59;
        recv_idle_pct = 19;
        set_limit(9'd16);
        hold_request = 1'b1;
        run_mix(60, 20, 4);
        set_limit(9'd2);
        run_mix(40, 4, 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(9'd256);
        run_fill();

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DICT_SIZE + 8) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
